### rtl/entity_id_allocator_macros.svh
// Assertion macros shared by the checker files of entity_id_allocator.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ENTITY_ID_ALLOCATOR_MACROS_SVH
`define ENTITY_ID_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define EIA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define EIA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/eia_pkg.sv
// Package for entity_id_allocator: sizes, operation and status codes,
// word types and the controller/datapath interface structs. No dependencies.
`default_nettype none

package eia_pkg;

    // Sizing
    localparam int ID_COUNT   = 1024;
    localparam int SIG_BITS   = 32;
    localparam int ID_W       = $clog2(ID_COUNT);
    localparam int CNT_W      = $clog2(ID_COUNT + 1);
    localparam int ENT_W      = SIG_BITS + 1;

    // Fixed field widths of the words
    localparam int MODE_W     = 2;
    localparam int TARGET_W   = 10;
    localparam int SIG_IN_W   = 32;
    localparam int NEW_ID_W   = 10;
    localparam int SIG_OUT_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int LIVE_W     = 11;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALIVE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [TARGET_W-1:0] target_id;
        logic [SIG_IN_W-1:0] signature_in;
    } req_t;

    typedef struct packed {
        logic [NEW_ID_W-1:0]  new_id;
        logic [SIG_OUT_W-1:0] signature_out;
        logic [STATUS_W-1:0]  status;
        logic [LIVE_W-1:0]    live_count;
    } rsp_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;   // request word taken this cycle, memory reads launched
        logic exec;     // read data valid, update state and load response
        logic clear;    // clearing pass: write one zero entry
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic clear_last;  // current clear write is the final entry
        logic out_free;    // response register empty or being drained
    } sts_t;

endpackage

`default_nettype wire

### rtl/eia_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone, no package dependency.
`default_nettype none

module eia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/eia_ctrl.sv
// Controller for entity_id_allocator: clearing pass, idle and execute states.
// Depends on eia_pkg.
`default_nettype none

module eia_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire eia_pkg::sts_t sts,
    output eia_pkg::cmd_t      cmd
);

    import eia_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;

    // Take a word only when idle and the response register will be free
    assign req_ready  = (state_reg == S_IDLE) && sts.out_free;
    assign cmd.accept = req_valid && req_ready;
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.clear  = (state_reg == S_CLEAR);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    if (sts.clear_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd.accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/eia_datapath.sv
// Datapath for entity_id_allocator: free ring, entity table (alive + signature),
// pointers, counters and the response register. Depends on eia_pkg, eia_ram.
`default_nettype none

module eia_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire eia_pkg::cmd_t cmd,
    output eia_pkg::sts_t      sts,
    input  wire eia_pkg::req_t req,
    output eia_pkg::rsp_t      rsp,
    output logic               rsp_valid,
    input  wire logic          rsp_ready
);

    import eia_pkg::*;

    localparam logic [ID_W-1:0]  LAST_ID  = ID_W'(ID_COUNT - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ID_COUNT);

    // Captured request
    logic [MODE_W-1:0]   mode_reg;
    logic [ID_W-1:0]     tid_reg;
    logic [SIG_BITS-1:0] sig_reg;
    logic                in_range_reg;

    // Allocator state
    logic [ID_W-1:0]  head_reg, head_next;
    logic [ID_W-1:0]  tail_reg, tail_next;
    logic             wrapped_reg, wrapped_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] alive_reg, alive_next;
    logic [ID_W-1:0]  clr_addr_reg;

    // Response register
    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg;

    // Memory ports
    logic             ent_wr_en;
    logic [ID_W-1:0]  ent_wr_addr;
    logic [ENT_W-1:0] ent_wr_data;
    logic [ENT_W-1:0] ent_rd_data;
    logic             ring_wr_en;
    logic [ID_W-1:0]  ring_rd_data;

    // Execute-stage decode
    logic                ent_alive;
    logic [SIG_BITS-1:0] ent_sig;
    logic                ring_written;
    logic [ID_W-1:0]     got_id;
    logic                ex_ent_wr;
    logic [ID_W-1:0]     ex_ent_addr;
    logic [ENT_W-1:0]    ex_ent_data;

    // Entity table: {alive, signature} per identifier, zeroed by the clear pass
    eia_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ID_COUNT)
    ) u_ent_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (req.target_id[ID_W-1:0]),
        .rd_data (ent_rd_data)
    );

    // Free ring: entries not yet pushed read as their own index
    eia_ram #(
        .WIDTH (ID_W),
        .DEPTH (ID_COUNT)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (tail_reg),
        .wr_data (tid_reg),
        .rd_en   (cmd.accept),
        .rd_addr (head_reg),
        .rd_data (ring_rd_data)
    );

    assign ent_alive    = ent_rd_data[SIG_BITS];
    assign ent_sig      = ent_rd_data[SIG_BITS-1:0];
    assign ring_written = wrapped_reg || (head_reg < tail_reg);
    assign got_id       = ring_written ? ring_rd_data : head_reg;

    // Execute: decide state updates and the response
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        wrapped_next = wrapped_reg;
        free_next    = free_reg;
        alive_next   = alive_reg;
        ring_wr_en   = 1'b0;
        ex_ent_wr    = 1'b0;
        ex_ent_addr  = tid_reg;
        ex_ent_data  = '0;
        rsp_next     = '0;
        rsp_next.status = ST_OK;

        if (cmd.exec)
        begin
            if (mode_reg == MODE_CREATE)
            begin
                if (free_reg == '0)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.new_id = NEW_ID_W'(got_id);
                    head_next   = (head_reg == LAST_ID) ? '0 : head_reg + 1'b1;
                    free_next   = free_reg - 1'b1;
                    alive_next  = alive_reg + 1'b1;
                    // a free identifier always has a zero signature
                    ex_ent_wr   = 1'b1;
                    ex_ent_addr = got_id;
                    ex_ent_data = {1'b1, {SIG_BITS{1'b0}}};
                end
            end
            else if (!in_range_reg)
            begin
                rsp_next.status = ST_RANGE;
            end
            else
            begin
                case (mode_reg)
                    MODE_REMOVE:
                    begin
                        if (!ent_alive)
                        begin
                            rsp_next.status = ST_NOT_ALIVE;
                        end
                        else
                        begin
                            ex_ent_wr   = 1'b1;
                            ex_ent_data = '0;
                            if (free_reg < FULL_CNT)
                            begin
                                ring_wr_en = 1'b1;
                                tail_next  = (tail_reg == LAST_ID) ? '0 : tail_reg + 1'b1;
                                if (tail_reg == LAST_ID)
                                begin
                                    wrapped_next = 1'b1;
                                end
                                free_next  = free_reg + 1'b1;
                            end
                            if (alive_reg != '0)
                            begin
                                alive_next = alive_reg - 1'b1;
                            end
                        end
                    end
                    MODE_SET:
                    begin
                        if (!ent_alive)
                        begin
                            rsp_next.status = ST_NOT_ALIVE;
                        end
                        else
                        begin
                            ex_ent_wr   = 1'b1;
                            ex_ent_data = {1'b1, sig_reg};
                        end
                    end
                    MODE_GET:
                    begin
                        rsp_next.signature_out = SIG_OUT_W'(ent_sig);
                        if (!ent_alive)
                        begin
                            rsp_next.status = ST_NOT_ALIVE;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_OK;
                    end
                endcase
            end
            rsp_next.live_count = LIVE_W'(alive_next);
        end
    end

    // Entity write port: clear pass or execute
    assign ent_wr_en   = cmd.clear || ex_ent_wr;
    assign ent_wr_addr = cmd.clear ? clr_addr_reg : ex_ent_addr;
    assign ent_wr_data = cmd.clear ? '0 : ex_ent_data;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg     <= req.mode;
            tid_reg      <= req.target_id[ID_W-1:0];
            sig_reg      <= SIG_BITS'(req.signature_in);
            in_range_reg <= (32'(req.target_id) < 32'(ID_COUNT));
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Control state: pointers, counters, clear address, response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            wrapped_reg   <= 1'b0;
            free_reg      <= FULL_CNT;
            alive_reg     <= '0;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            wrapped_reg <= wrapped_next;
            free_reg    <= free_next;
            alive_reg   <= alive_next;
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clear_last = cmd.clear && (clr_addr_reg == LAST_ID);
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;
    assign rsp            = rsp_reg;
    assign rsp_valid      = rsp_valid_reg;

endmodule

`default_nettype wire

### rtl/entity_id_allocator.sv
// Top level of entity_id_allocator: controller plus datapath.
// Depends on eia_pkg, eia_ctrl, eia_datapath, eia_ram.
//
// Hands out identifiers 0..1023 from a FIFO free list (oldest freed first),
// and keeps an alive flag and a 32-bit signature per identifier. Each request
// word (create, remove, set, get) gives exactly one response word carrying the
// new identifier, the stored signature, a status and the live count. After
// reset the block runs a clearing pass over the whole entity table with
// req_ready low. For each word, the accept cycle launches the reads
// of the free ring and the entity table, and the next cycle executes with the
// registered read data, writes back and loads the response register. A new
// word can then be taken in the following cycle while rsp_ready is high; the
// block never takes a new word before the last one has executed.
`default_nettype none

module entity_id_allocator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire eia_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output eia_pkg::rsp_t      rsp
);

    import eia_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    eia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Storage and update logic
    eia_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule

`default_nettype wire

### rtl/eia_checker.sv
// Port-level checks for entity_id_allocator, bound to the top level.
// Depends on eia_pkg and entity_id_allocator_macros.svh.
`default_nettype none
`include "entity_id_allocator_macros.svh"

module eia_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_ready,
    input  wire eia_pkg::rsp_t rsp
);

    import eia_pkg::*;

    // A stalled response word holds
    `EIA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response word changed while stalled")

    // Only a successful create hands out an identifier
    `EIA_ASSERT_IMP(a_new_id_zero, rsp_valid && (rsp.status != ST_OK), rsp.new_id == '0, "new_id set on a failed word")

    // Live count never exceeds the identifier space
    `EIA_ASSERT_IMP(a_live_bound, rsp_valid, 32'(rsp.live_count) <= 32'(ID_COUNT), "live count above identifier count")

    // No free identifier means every identifier is live
    `EIA_ASSERT_IMP(a_full_count, rsp_valid && (rsp.status == ST_FULL), 32'(rsp.live_count) == 32'(ID_COUNT), "full status with identifiers still free")

endmodule

bind entity_id_allocator eia_checker u_eia_checker (.*);

`default_nettype wire

### sim/entity_id_allocator_tb.sv
// Self-checking testbench for entity_id_allocator: a directed table, then
// random create/remove/set/get words checked against an in-bench free-list model.
// Depends on eia_pkg and the entity_id_allocator RTL.
`timescale 1ns / 100ps

module entity_id_allocator_tb;

    import eia_pkg::*;

    localparam int IDLE_LIMIT = 5000;  // covers the clearing pass after reset
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        req_t word;
        logic typed;
        rsp_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Free-list model state
    logic [ID_W-1:0]     free_ring [ID_COUNT];
    int unsigned         ring_rd;
    int unsigned         ring_wr;
    int                  free_n;
    bit                  alive [ID_COUNT];
    logic [SIG_OUT_W-1:0] sig_mem [ID_COUNT];
    int                  live_n;

    rsp_t owed_rsp [$];
    plan_row_t plan [$];
    int errors;
    int idle_cyc;
    int tx_mode;
    bit hold_rsp;

    entity_id_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Expected response for one word; updates the model state
    task automatic run_id_op(input req_t w, output rsp_t r);
        int id;
        id = int'(w.target_id);
        r = '0;
        if (w.mode == MODE_CREATE)
        begin
            if (free_n == 0)
                r.status = ST_FULL;
            else
            begin
                r.new_id = free_ring[ring_rd];
                alive[free_ring[ring_rd]] = 1'b1;
                ring_rd = (ring_rd + 1) % ID_COUNT;
                free_n--;
                live_n++;
            end
        end
        else if (id >= ID_COUNT)
            r.status = ST_RANGE;
        else if (w.mode == MODE_REMOVE)
        begin
            if (!alive[id])
                r.status = ST_NOT_ALIVE;
            else
            begin
                sig_mem[id] = '0;
                alive[id] = 1'b0;
                if (free_n < ID_COUNT)
                begin
                    free_ring[ring_wr] = w.target_id;
                    ring_wr = (ring_wr + 1) % ID_COUNT;
                    free_n++;
                end
                if (live_n > 0)
                    live_n--;
            end
        end
        else if (w.mode == MODE_SET)
        begin
            if (!alive[id])
                r.status = ST_NOT_ALIVE;
            else
                sig_mem[id] = w.signature_in;
        end
        else
        begin
            r.signature_out = sig_mem[id];
            if (!alive[id])
                r.status = ST_NOT_ALIVE;
        end
        r.live_count = LIVE_W'(live_n);
    endtask

    // Sender gap: none in calm stretches, else mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_mode == 0 || r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Next live identifier at or after start, wrapping
    function automatic logic [TARGET_W-1:0] find_live(int start);
        int idx;
        for (int k = 0; k < ID_COUNT; k++)
        begin
            idx = (start + k) % ID_COUNT;
            if (alive[idx])
                return TARGET_W'(idx);
        end
        return TARGET_W'(start);
    endfunction

    // Random word, mostly aimed at live identifiers
    function automatic req_t rand_word(int pct_create, int pct_remove);
        req_t w;
        int r;
        r = $urandom_range(0, 99);
        if (r < pct_create)
            w.mode = MODE_CREATE;
        else if (r < pct_create + pct_remove)
            w.mode = MODE_REMOVE;
        else
            w.mode = r[0] ? MODE_SET : MODE_GET;
        w.target_id = TARGET_W'($urandom);
        if (live_n > 0 && $urandom_range(0, 99) < 80)
            w.target_id = find_live(int'(w.target_id));
        r = $urandom_range(0, 9);
        if (r == 0)
            w.signature_in = '0;
        else if (r == 1)
            w.signature_in = '1;
        else
            w.signature_in = $urandom;
        return w;
    endfunction

    // Offer one word, wait for acceptance, then book its expected response
    task automatic send_word(input req_t w, input bit typed, input rsp_t typed_rsp);
        int gap;
        rsp_t calc;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req <= w;
        do @(posedge clk); while (!req_ready);
        run_id_op(w, calc);
        owed_rsp.push_back(typed ? typed_rsp : calc);
    endtask

    function automatic plan_row_t row(logic [MODE_W-1:0] m, int id, logic [31:0] sig,
                                      bit typed, int nid, logic [31:0] sout,
                                      logic [STATUS_W-1:0] st, int live);
        plan_row_t p;
        p.word = '{mode: m, target_id: TARGET_W'(id), signature_in: sig};
        p.typed = typed;
        p.want = '{new_id: NEW_ID_W'(nid), signature_out: sout, status: st,
                   live_count: LIVE_W'(live)};
        return p;
    endfunction

    // Response side: random stalls per stretch, plus one long hold-off on request
    initial
    begin : rsp_side
        int stall;
        int span_left;
        int rx_mode;
        int r;
        stall = 0;
        span_left = 0;
        rx_mode = 0;
        rsp_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (span_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                span_left = $urandom_range(50, 250);
            end
            span_left--;
            if (stall == 0 && rx_mode != 0)
            begin
                r = $urandom_range(0, 99);
                if (rx_mode == 2 && r < 3)
                    stall = $urandom_range(10, 40);
                else if (r < 30)
                    stall = $urandom_range(1, 3);
            end
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                stall--;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Response check against the oldest expected word
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (owed_rsp.size() == 0)
            begin
                $error("response word with nothing pending");
                errors++;
            end
            else
            begin
                want = owed_rsp.pop_front();
                if (rsp.new_id !== want.new_id)
                begin
                    $error("new_id: expected %0d, got %0d", want.new_id, rsp.new_id);
                    errors++;
                end
                if (rsp.signature_out !== want.signature_out)
                begin
                    $error("signature_out: expected %h, got %h",
                           want.signature_out, rsp.signature_out);
                    errors++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.live_count !== want.live_count)
                begin
                    $error("live_count: expected %0d, got %0d",
                           want.live_count, rsp.live_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= IDLE_LIMIT)
        begin
            $display("entity_id_allocator: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        rsp_t none;
        none = '0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        errors = 0;
        idle_cyc = 0;
        tx_mode = 0;
        hold_rsp = 1'b0;
        for (int i = 0; i < ID_COUNT; i++)
        begin
            free_ring[i] = ID_W'(i);
            alive[i] = 1'b0;
            sig_mem[i] = '0;
        end
        ring_rd = 0;
        ring_wr = 0;
        free_n = ID_COUNT;
        live_n = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: reads and writes of dead ids, first creates, FIFO reuse
        plan.push_back(row(MODE_GET,    0,    32'h0,        1, 0, 32'h0, ST_NOT_ALIVE, 0));
        plan.push_back(row(MODE_REMOVE, 1023, 32'h0,        1, 0, 32'h0, ST_NOT_ALIVE, 0));
        plan.push_back(row(MODE_SET,    0,    32'hFFFFFFFF, 1, 0, 32'h0, ST_NOT_ALIVE, 0));
        plan.push_back(row(MODE_GET,    1023, 32'hFFFFFFFF, 1, 0, 32'h0, ST_NOT_ALIVE, 0));
        plan.push_back(row(MODE_CREATE, 1023, 32'hFFFFFFFF, 1, 0, 32'h0, ST_OK, 1));
        plan.push_back(row(MODE_CREATE, 0,    32'h0,        1, 1, 32'h0, ST_OK, 2));
        plan.push_back(row(MODE_SET,    0,    32'hFFFFFFFF, 1, 0, 32'h0, ST_OK, 2));
        plan.push_back(row(MODE_GET,    0,    32'h0,        1, 0, 32'hFFFFFFFF, ST_OK, 2));
        plan.push_back(row(MODE_SET,    1,    32'h0,        1, 0, 32'h0, ST_OK, 2));
        plan.push_back(row(MODE_GET,    1,    32'h0,        1, 0, 32'h0, ST_OK, 2));
        plan.push_back(row(MODE_SET,    1,    32'hA5A55A5A, 0, 0, 32'h0, ST_OK, 0));
        plan.push_back(row(MODE_GET,    1,    32'h0,        0, 0, 32'h0, ST_OK, 0));
        plan.push_back(row(MODE_REMOVE, 0,    32'h0,        1, 0, 32'h0, ST_OK, 1));
        plan.push_back(row(MODE_GET,    0,    32'h0,        1, 0, 32'h0, ST_NOT_ALIVE, 1));
        plan.push_back(row(MODE_REMOVE, 0,    32'h0,        1, 0, 32'h0, ST_NOT_ALIVE, 1));
        plan.push_back(row(MODE_SET,    0,    32'h00001234, 1, 0, 32'h0, ST_NOT_ALIVE, 1));
        plan.push_back(row(MODE_CREATE, 0,    32'h0,        1, 2, 32'h0, ST_OK, 2));
        plan.push_back(row(MODE_REMOVE, 1,    32'h0,        0, 0, 32'h0, ST_OK, 0));
        plan.push_back(row(MODE_GET,    1,    32'h0,        0, 0, 32'h0, ST_OK, 0));
        plan.push_back(row(MODE_REMOVE, 2,    32'h0,        0, 0, 32'h0, ST_OK, 0));
        plan.push_back(row(MODE_GET,    1023, 32'h0,        0, 0, 32'h0, ST_OK, 0));
        foreach (plan[i])
            send_word(plan[i].word, plan[i].typed, plan[i].want);

        // Mixed traffic with a slow upward drift of the live count
        for (int i = 0; i < 300; i++)
        begin
            if (i % 100 == 0)
                tx_mode = $urandom_range(0, 1);
            send_word(rand_word(40, 20), 1'b0, none);
        end

        // Let every pending response come home before the next phase
        @(negedge clk);
        req_valid <= 1'b0;
        while (owed_rsp.size() != 0)
            @(posedge clk);

        // Fill the table while the response side holds off at first
        tx_mode = 1;
        hold_rsp = 1'b1;
        while (free_n != 0)
            send_word(rand_word(92, 0), 1'b0, none);

        // Creates against a full table, with some removes freeing ids again
        send_word(rand_word(100, 0), 1'b0, none);
        for (int i = 0; i < 11; i++)
            send_word(rand_word(75, 8), 1'b0, none);

        // Drain-heavy traffic, then a final mix
        tx_mode = 0;
        for (int i = 0; i < 200; i++)
        begin
            if (i % 100 == 50)
                tx_mode = $urandom_range(0, 1);
            send_word(rand_word(10, 60), 1'b0, none);
        end
        tx_mode = 1;
        for (int i = 0; i < 150; i++)
            send_word(rand_word(35, 35), 1'b0, none);

        @(negedge clk);
        req_valid <= 1'b0;
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("entity_id_allocator: match");
        else
            $display("entity_id_allocator: mismatch");
        $finish;
    end

endmodule
